FILE: rtl/momentum_scroll_engine_top_macros.svh
// Assertion macros shared by the momentum scroll engine RTL.
// Included by modules that carry concurrent assertions.
`ifndef MOMENTUM_SCROLL_ENGINE_TOP_MACROS_SVH
`define MOMENTUM_SCROLL_ENGINE_TOP_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define MSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: rtl/mse_pkg.sv
// Package for the momentum scroll engine: mode codes, sequencer states, widths.
// No dependencies.
package mse_pkg;
	typedef enum logic [1:0] {
		MODE_START   = 2'd0,
		MODE_SAMPLE  = 2'd1,
		MODE_RELEASE = 2'd2,
		MODE_TICK    = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_MULX,
		ST_DIVX,
		ST_MULY,
		ST_DIVY,
		ST_DCX,
		ST_DCY,
		ST_TMX,
		ST_TDX,
		ST_TMY,
		ST_TDY,
		ST_OUT
	} state_t;

	localparam int unsigned REG_DECAY_COEF = 0;
	localparam logic [15:0] DECAY_RESET    = 16'd983;
	localparam int unsigned ACC_W          = 64;
	localparam int unsigned CNT_W          = 7;

	// Control from the sequencer to the serial arithmetic unit.
	typedef struct packed {
		logic load_mul;
		logic load_div;
	} ctl_t;
endpackage

FILE: rtl/mse_mul.sv
// Bit-serial shift-add multiplier, unsigned magnitudes, one multiplier bit a cycle.
// Depends on mse_pkg.
module mse_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mse_pkg::ACC_W-1:0]  a,
	input  logic [31:0]                b,
	output logic [mse_pkg::ACC_W-1:0]  prod,
	output logic                       busy
);
	logic [mse_pkg::ACC_W-1:0] acc_q;
	logic [mse_pkg::ACC_W-1:0] a_q;
	logic [31:0]               b_q;
	logic [5:0]                cnt_q;
	logic                      busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd31;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd0) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= {a_q[mse_pkg::ACC_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[31:1]};
		end
	end

	assign prod = acc_q;
	assign busy = busy_q;
endmodule

FILE: rtl/mse_div.sv
// Restoring bit-serial divider, 64 by 32 bit unsigned, one quotient bit a cycle.
// Depends on mse_pkg.
module mse_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mse_pkg::ACC_W-1:0]  num,
	input  logic [31:0]                den,
	output logic [mse_pkg::ACC_W-1:0]  quo,
	output logic                       busy
);
	logic [mse_pkg::ACC_W-1:0] q_q;
	logic [32:0]               r_q;
	logic [31:0]               d_q;
	logic [6:0]                cnt_q;
	logic                      busy_q;
	logic [32:0]               trial;
	logic [33:0]               diff;

	assign trial = {r_q[31:0], q_q[mse_pkg::ACC_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'd63;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd0) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (!diff[33]) begin
				r_q <= diff[32:0];
				q_q <= {q_q[mse_pkg::ACC_W-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[mse_pkg::ACC_W-2:0], 1'b0};
			end
		end
	end

	assign quo  = q_q;
	assign busy = busy_q;
endmodule

FILE: rtl/momentum_scroll_engine_top.sv
// Top level of the momentum scroll engine: window, sequencer, serial math.
// Depends on mse_pkg, mse_mul, mse_div and the assertion macro header.
//
// Each input transfer yields exactly one output transfer. A start or sample
// item, or a tick with both velocities zero, has its result registered at the
// input transfer and valid in the cycle after it. Release sums the window one
// entry a cycle. Per axis it then runs a serial multiply and a serial divide,
// and then a multiply for each deceleration. A tick with motion runs a multiply
// and a divide per axis. The bit-serial multiplier and the restoring divider
// set the pace of these steps. A finished result waits in the output register;
// the next item is taken when that register is free. The decay coefficient
// sits at address 0.
`include "momentum_scroll_engine_top_macros.svh"
module momentum_scroll_engine_top #(
	parameter int WINDOW_DEPTH = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: sample_dx[15:0], sample_dy[31:16], elapsed_ms[47:32]
	input  logic [47:0] s_tdata,
	// s_tuser: mode[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: move_x[31:0], move_y[63:32], moving[64], zero fill up to bit 71
	output logic [71:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FW = $clog2(WINDOW_DEPTH + 1);

	mse_pkg::state_t state_q, state_d;

	logic [15:0] decay_q;
	logic [15:0] win_dx_q [WINDOW_DEPTH];
	logic [15:0] win_dy_q [WINDOW_DEPTH];
	logic [15:0] win_dt_q [WINDOW_DEPTH];
	logic [FW-1:0] fill_q;
	logic [IW-1:0] slot_q;
	logic [FW-1:0] idx_q;
	logic [IW-1:0] rd_idx;
	logic signed [31:0] velx_q, vely_q, decx_q, decy_q;
	logic signed [31:0] sx_q, sy_q;
	logic [31:0] st_q;
	logic [15:0] ms_q;
	logic signed [31:0] mx_q, my_q;
	logic        mv_q;
	logic        out_v_q;
	logic [71:0] out_q;

	logic s_fire, m_fire;
	logic [1:0] mode;
	logic [15:0] in_dx, in_dy, in_ms;

	mse_pkg::ctl_t ctl;
	logic [mse_pkg::ACC_W-1:0] mul_a, mul_p, div_n, div_q;
	logic [31:0] mul_b, div_d;
	logic mul_busy, div_busy;

	assign mode  = s_tuser;
	assign in_dx = s_tdata[15:0];
	assign in_dy = s_tdata[31:16];
	assign in_ms = s_tdata[47:32];

	assign rd_idx = idx_q[IW-1:0];

	assign s_tready = (state_q == mse_pkg::ST_IDLE) && !out_v_q;
	assign s_fire   = s_tvalid && s_tready;
	assign m_fire   = m_tvalid && m_tready;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? {16'd0, decay_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) decay_q <= mse_pkg::DECAY_RESET;
		else if (psel && penable && pwrite && paddr == 1'b0) decay_q <= pwdata[15:0];
	end

	// Signed magnitude helpers.
	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		mag64 = v[63] ? 64'(-v) : 64'(v);
	endfunction

	// Saturate a signed result given as sign and unsigned 64-bit magnitude.
	function automatic logic [31:0] sat_sm(input logic neg, input logic [63:0] m);
		if (!neg) sat_sm = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
		else sat_sm = (m > 64'h8000_0000) ? 32'h8000_0000 : 32'(-m[31:0]);
	endfunction

	// Truncating negation for deceleration: -(sign * (m >> 16)).
	function automatic logic [31:0] neg_dec(input logic neg, input logic [63:0] m);
		logic [31:0] t;
		t = m[47:16];
		neg_dec = neg ? t : 32'(-t);
	endfunction

	function automatic logic signed [31:0] decay(input logic signed [31:0] v,
			input logic signed [31:0] d);
		logic signed [32:0] s;
		logic signed [31:0] nv;
		s = 33'(v) + 33'(d);
		if (s > 33'sh0_7FFF_FFFF) nv = 32'sh7FFF_FFFF;
		else if (s < -33'sh0_8000_0000) nv = 32'sh8000_0000;
		else nv = s[31:0];
		if (v == 0) decay = v;
		else if ((v < 0 && nv > 0) || (v > 0 && nv < 0)) decay = '0;
		else decay = nv;
	endfunction

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mse_pkg::ST_IDLE: begin
				if (s_fire) begin
					if (mode == mse_pkg::MODE_RELEASE) state_d = mse_pkg::ST_SUM;
					else if (mode == mse_pkg::MODE_TICK && (velx_q != 0 || vely_q != 0))
						state_d = mse_pkg::ST_TMX;
				end
			end
			mse_pkg::ST_SUM: if (32'(idx_q) >= 32'(fill_q)) state_d = mse_pkg::ST_MULX;
			mse_pkg::ST_MULX: if (!mul_busy) state_d = mse_pkg::ST_DIVX;
			mse_pkg::ST_DIVX: if (!div_busy) state_d = mse_pkg::ST_MULY;
			mse_pkg::ST_MULY: if (!mul_busy) state_d = mse_pkg::ST_DIVY;
			mse_pkg::ST_DIVY: if (!div_busy) state_d = mse_pkg::ST_DCX;
			mse_pkg::ST_DCX: if (!mul_busy) state_d = mse_pkg::ST_DCY;
			mse_pkg::ST_DCY: if (!mul_busy) state_d = mse_pkg::ST_OUT;
			mse_pkg::ST_TMX: if (!mul_busy) state_d = mse_pkg::ST_TDX;
			mse_pkg::ST_TDX: if (!div_busy) state_d = mse_pkg::ST_TMY;
			mse_pkg::ST_TMY: if (!mul_busy) state_d = mse_pkg::ST_TDY;
			mse_pkg::ST_TDY: if (!div_busy) state_d = mse_pkg::ST_OUT;
			mse_pkg::ST_OUT: state_d = mse_pkg::ST_IDLE;
			default: state_d = mse_pkg::ST_IDLE;
		endcase
	end

	// Unit operand selection and start strobes. A unit starts on the cycle its
	// state is entered; the entering transition raises the strobe.
	logic entering;
	assign entering = (state_d != state_q);

	always_comb begin
		ctl   = '0;
		mul_a = '0;
		mul_b = '0;
		div_n = '0;
		div_d = 32'd1;
		case (state_d)
			mse_pkg::ST_MULX: begin
				ctl.load_mul = entering;
				mul_a = mag64(64'(sx_q));
				mul_b = 32'd256000;
			end
			mse_pkg::ST_MULY: begin
				ctl.load_mul = entering;
				mul_a = mag64(64'(sy_q));
				mul_b = 32'd256000;
			end
			mse_pkg::ST_DIVX, mse_pkg::ST_DIVY: begin
				ctl.load_div = entering;
				div_n = mul_p;
				div_d = st_q;
			end
			mse_pkg::ST_DCX: begin
				ctl.load_mul = entering;
				mul_a = mag64(64'(velx_q));
				mul_b = {16'd0, decay_q};
			end
			mse_pkg::ST_DCY: begin
				ctl.load_mul = entering;
				mul_a = mag64(64'(vely_q));
				mul_b = {16'd0, decay_q};
			end
			mse_pkg::ST_TMX: begin
				ctl.load_mul = entering;
				mul_a = mag64(64'(velx_q));
				mul_b = {16'd0, (s_fire ? in_ms : ms_q)};
			end
			mse_pkg::ST_TMY: begin
				ctl.load_mul = entering;
				mul_a = mag64(64'(vely_q));
				mul_b = {16'd0, ms_q};
			end
			mse_pkg::ST_TDX, mse_pkg::ST_TDY: begin
				ctl.load_div = entering;
				div_n = mul_p;
				div_d = 32'd1000;
			end
			default: ;
		endcase
	end

	mse_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(ctl.load_mul),
		.a(mul_a), .b(mul_b), .prod(mul_p), .busy(mul_busy)
	);

	mse_div u_div (
		.clk(clk), .arst_n(arst_n), .start(ctl.load_div),
		.num(div_n), .den(div_d), .quo(div_q), .busy(div_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mse_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// Datapath and state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			slot_q  <= '0;
			idx_q   <= '0;
			velx_q  <= '0;
			vely_q  <= '0;
			decx_q  <= '0;
			decy_q  <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			st_q    <= '0;
			ms_q    <= '0;
			mx_q    <= '0;
			my_q    <= '0;
			mv_q    <= 1'b0;
			out_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (m_fire) out_v_q <= 1'b0;
			if (s_fire) begin
				ms_q <= in_ms;
				mx_q <= '0;
				my_q <= '0;
				mv_q <= 1'b0;
				case (mode)
					mse_pkg::MODE_START: begin
						fill_q <= '0;
						slot_q <= '0;
						velx_q <= '0;
						vely_q <= '0;
						decx_q <= '0;
						decy_q <= '0;
					end
					mse_pkg::MODE_SAMPLE: begin
						slot_q <= (32'(slot_q) == WINDOW_DEPTH - 1) ? '0 : IW'(slot_q + 1'b1);
						if (32'(fill_q) < WINDOW_DEPTH) fill_q <= FW'(fill_q + 1'b1);
					end
					mse_pkg::MODE_RELEASE: begin
						idx_q <= '0;
						sx_q  <= '0;
						sy_q  <= '0;
						st_q  <= '0;
					end
					default: ;
				endcase
				if (!(mode == mse_pkg::MODE_RELEASE ||
						(mode == mse_pkg::MODE_TICK && (velx_q != 0 || vely_q != 0)))) begin
					out_v_q <= 1'b1;
					out_q   <= '0;
				end
			end
			case (state_q)
				mse_pkg::ST_SUM: begin
					// The index runs one past the last valid entry to end the pass.
					if (32'(idx_q) < 32'(fill_q)) begin
						sx_q  <= sx_q + 32'(signed'(win_dx_q[rd_idx]));
						sy_q  <= sy_q + 32'(signed'(win_dy_q[rd_idx]));
						st_q  <= st_q + {16'd0, win_dt_q[rd_idx]};
						idx_q <= FW'(idx_q + 1'b1);
					end
				end
				mse_pkg::ST_DIVX: if (!div_busy) velx_q <= (st_q == 0) ? '0 :
					sat_sm(sx_q[31], div_q);
				mse_pkg::ST_DIVY: if (!div_busy) vely_q <= (st_q == 0) ? '0 :
					sat_sm(sy_q[31], div_q);
				mse_pkg::ST_DCX: if (!mul_busy) decx_q <= neg_dec(velx_q[31], mul_p);
				mse_pkg::ST_DCY: if (!mul_busy) begin
					decy_q <= neg_dec(vely_q[31], mul_p);
					fill_q <= '0;
					slot_q <= '0;
				end
				mse_pkg::ST_TDX: if (!div_busy) mx_q <= sat_sm(velx_q[31], div_q);
				mse_pkg::ST_TDY: if (!div_busy) begin
					my_q   <= sat_sm(vely_q[31], div_q);
					mv_q   <= 1'b1;
					velx_q <= decay(velx_q, decx_q);
					vely_q <= decay(vely_q, decy_q);
				end
				mse_pkg::ST_OUT: begin
					out_v_q <= 1'b1;
					out_q   <= {7'd0, mv_q, my_q, mx_q};
				end
				default: ;
			endcase
		end
	end

	// Window storage; entries are only read below the fill count.
	always_ff @(posedge clk) begin
		if (s_fire && mode == mse_pkg::MODE_SAMPLE) begin
			win_dx_q[slot_q] <= in_dx;
			win_dy_q[slot_q] <= in_dy;
			win_dt_q[slot_q] <= in_ms;
		end
	end

	`MSE_ASSERT_IMP(a_busy_no_accept, clk, arst_n, state_q != mse_pkg::ST_IDLE, !s_tready)
	`MSE_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, 32'(fill_q) <= WINDOW_DEPTH)
	`MSE_ASSERT_NEXT(a_out_follows, clk, arst_n, state_q == mse_pkg::ST_OUT, m_tvalid)
	`MSE_ASSERT_IMP(a_units_excl, clk, arst_n, 1'b1, !(mul_busy && div_busy))
endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for momentum_scroll_engine_top: drives start, sample, release and
// tick items on the stream port and checks each result against a local predictor or typed value.
// Depends on mse_pkg and the engine RTL.
`timescale 1ns / 100ps
module tb_top;
	localparam int DEPTH = 10;
	localparam int N_RANDOM = 1350;
	localparam longint CYCLE_LIMIT = 64'd3000000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [0:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	momentum_scroll_engine_top #(.WINDOW_DEPTH(DEPTH)) i_dut (.*);

	// One scroll event as the sender presents it.
	typedef struct packed {
		mse_pkg::mode_t mode;
		logic [15:0]    dx;
		logic [15:0]    dy;
		logic [15:0]    ms;
	} scroll_ev_t;

	// One displacement report, laid out as on m_tdata from the top bit down.
	typedef struct packed {
		logic        moving;
		logic [31:0] move_y;
		logic [31:0] move_x;
	} motion_t;

	// One directed row: the event and, where given, its typed-in result.
	typedef struct packed {
		scroll_ev_t ev;
		logic       has_exp;
		motion_t    exp;
	} dir_row_t;

	localparam motion_t NO_MOTION  = '0;
	localparam motion_t SAT_MOTION = '{moving: 1'b1, move_y: 32'h8000_0000,
		move_x: 32'h7FFF_FFFF};

	// Predictor state: the sample window, velocities, decelerations, coefficient.
	logic signed [15:0] win_dx [DEPTH];
	logic signed [15:0] win_dy [DEPTH];
	logic [15:0]        win_dt [DEPTH];
	int                 win_fill;
	int                 win_slot;
	longint             vel_x, vel_y, dec_x, dec_y;
	longint             coef;

	motion_t     motion_q[$];
	int          mismatches;
	int          sent;
	longint      cycles;
	bit          hold_rx;      // long receiver hold-off request
	int          dir_idx;

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = 1'b1;
			#5 clk = 1'b0;
		end
	end

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Adds the deceleration to one axis; an axis that would change sign stops.
	function automatic longint decay_axis(longint v, longint d);
		longint nv;
		if (v == 0) return 0;
		nv = sat32(v + d);
		if ((v < 0 && nv > 0) || (v > 0 && nv < 0)) nv = 0;
		return nv;
	endfunction

	// Advances the predictor by one event and returns the report it must produce.
	function automatic motion_t predict_motion(scroll_ev_t ev);
		motion_t r;
		longint sx, sy, st;
		r = '0;
		case (ev.mode)
			mse_pkg::MODE_START: begin
				win_fill = 0; win_slot = 0;
				vel_x = 0; vel_y = 0; dec_x = 0; dec_y = 0;
			end
			mse_pkg::MODE_SAMPLE: begin
				win_dx[win_slot] = ev.dx;
				win_dy[win_slot] = ev.dy;
				win_dt[win_slot] = ev.ms;
				win_slot = (win_slot + 1) % DEPTH;
				if (win_fill < DEPTH) win_fill++;
			end
			mse_pkg::MODE_RELEASE: begin
				sx = 0; sy = 0; st = 0;
				for (int i = 0; i < win_fill; i++) begin
					sx += longint'(win_dx[i]);
					sy += longint'(win_dy[i]);
					st += longint'(win_dt[i]);
				end
				if (st == 0) begin
					vel_x = 0; vel_y = 0;
				end else begin
					vel_x = sat32((sx * 256000) / st);
					vel_y = sat32((sy * 256000) / st);
				end
				dec_x = -((vel_x * coef) / 65536);
				dec_y = -((vel_y * coef) / 65536);
				win_fill = 0; win_slot = 0;
			end
			default: begin
				if (vel_x != 0 || vel_y != 0) begin
					r.move_x = 32'(sat32((vel_x * longint'(ev.ms)) / 1000));
					r.move_y = 32'(sat32((vel_y * longint'(ev.ms)) / 1000));
					r.moving = 1'b1;
					vel_x = decay_axis(vel_x, dec_x);
					vel_y = decay_axis(vel_y, dec_y);
				end
			end
		endcase
		return r;
	endfunction

	// Random gap: mostly zero or short, now and then long.
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	task automatic idle_cycles(int n);
		repeat (n) @(negedge clk);
	endtask

	// Offers one event and waits for its transfer; the expectation is queued
	// at the accepting edge so it is always ahead of the matching result.
	// A typed-in result, where given, replaces the predicted one.
	task automatic send_event(scroll_ev_t ev, bit has_exp = 1'b0, motion_t exp = '0);
		motion_t want;
		s_tuser  = ev.mode;
		s_tdata  = {ev.ms, ev.dy, ev.dx};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		want = predict_motion(ev);
		motion_q.push_back(has_exp ? exp : want);
		sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// Register write through the setup and access phases.
	task automatic write_coef(logic [15:0] value);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 1'(mse_pkg::REG_DECAY_COEF); pwdata <= {16'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		coef = value;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Waits for every expected report, then for the slowest operation to drain.
	task automatic drain_results();
		while (motion_q.size() != 0) @(negedge clk);
		idle_cycles(400);
	endtask

	function automatic scroll_ev_t make_ev(mse_pkg::mode_t m, int dx, int dy, int ms);
		scroll_ev_t ev;
		ev.mode = m; ev.dx = 16'(dx); ev.dy = 16'(dy); ev.ms = 16'(ms);
		return ev;
	endfunction

	function automatic dir_row_t make_row(mse_pkg::mode_t m, int dx, int dy, int ms,
			logic has_exp, motion_t exp);
		dir_row_t r;
		r.ev = make_ev(m, dx, dy, ms);
		r.has_exp = has_exp;
		r.exp = exp;
		return r;
	endfunction

	function automatic scroll_ev_t rand_sample();
		int p;
		p = $urandom_range(0, 9);
		if (p == 0) return make_ev(mse_pkg::MODE_SAMPLE, $urandom, $urandom, $urandom);
		return make_ev(mse_pkg::MODE_SAMPLE, $urandom_range(0, 400) - 200,
			$urandom_range(0, 400) - 200, $urandom_range(0, 40));
	endfunction

	// Result checker: compares each transfer with the oldest expectation.
	always @(posedge clk) begin
		motion_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[64:0];
			if (motion_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
			end else begin
				want = motion_q.pop_front();
				if (got !== want || m_tdata[71:65] !== '0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp x=%h y=%h mv=%b got x=%h y=%h mv=%b",
							want.move_x, want.move_y, want.moving,
							got.move_x, got.move_y, got.moving);
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int g;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				m_tready <= 1'b0;
				repeat (3000) @(negedge clk);
				hold_rx = 1'b0;
			end
			g = gap_len();
			if (g == 0 || $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				repeat (g - 1) @(negedge clk);
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Directed rows: extremes, every mode and the special cases, in order.
	dir_row_t directed [] = '{
		// tick with no velocity after reset
		make_row(mse_pkg::MODE_TICK, 100, 100, 16, 1'b1, NO_MOTION),
		// release of an empty window
		make_row(mse_pkg::MODE_RELEASE, 0, 0, 0, 1'b1, NO_MOTION),
		make_row(mse_pkg::MODE_SAMPLE, 32767, -32768, 0, 1'b1, NO_MOTION),
		// zero total time
		make_row(mse_pkg::MODE_RELEASE, 0, 0, 0, 1'b1, NO_MOTION),
		make_row(mse_pkg::MODE_SAMPLE, 32767, -32768, 1, 1'b1, NO_MOTION),
		// saturated velocity
		make_row(mse_pkg::MODE_RELEASE, 0, 0, 0, 1'b1, NO_MOTION),
		// saturated displacement
		make_row(mse_pkg::MODE_TICK, 0, 0, 65535, 1'b1, SAT_MOTION),
		make_row(mse_pkg::MODE_TICK, 0, 0, 0, 1'b0, NO_MOTION),
		// start clears motion
		make_row(mse_pkg::MODE_START, -1, -1, 65535, 1'b1, NO_MOTION),
		make_row(mse_pkg::MODE_TICK, 0, 0, 16, 1'b1, NO_MOTION),
		make_row(mse_pkg::MODE_SAMPLE, 10, -5, 16, 1'b0, NO_MOTION),
		make_row(mse_pkg::MODE_SAMPLE, 12, -6, 17, 1'b0, NO_MOTION),
		make_row(mse_pkg::MODE_SAMPLE, 0, 0, 65535, 1'b0, NO_MOTION),
		make_row(mse_pkg::MODE_RELEASE, 0, 0, 0, 1'b0, NO_MOTION),
		make_row(mse_pkg::MODE_TICK, 0, 0, 16, 1'b0, NO_MOTION),
		make_row(mse_pkg::MODE_TICK, 0, 0, 65535, 1'b0, NO_MOTION)
	};

	initial begin
		scroll_ev_t ev;
		int p;
		arst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = mse_pkg::MODE_START;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		mismatches = 0; sent = 0; cycles = 0; hold_rx = 1'b0;
		coef = mse_pkg::DECAY_RESET;
		win_fill = 0; win_slot = 0; vel_x = 0; vel_y = 0; dec_x = 0; dec_y = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset coefficient: rows whose result is plain zero are checked here too.
		for (dir_idx = 0; dir_idx < directed.size(); dir_idx++)
			send_event(directed[dir_idx].ev, directed[dir_idx].has_exp,
				directed[dir_idx].exp);
		drain_results();

		// Full window wrap with many samples under both coefficient extremes, a random one and reset.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_coef(16'hFFFF);
				1: write_coef(16'd0);
				2: write_coef(16'(32768 + $urandom_range(0, 32767)));
				default: write_coef(mse_pkg::DECAY_RESET);
			endcase
			for (int i = 0; i < 14; i++) send_event(rand_sample());
			send_event(make_ev(mse_pkg::MODE_RELEASE, $urandom, $urandom, $urandom));
			for (int i = 0; i < 6; i++)
				send_event(make_ev(mse_pkg::MODE_TICK, $urandom, $urandom,
					$urandom_range(0, 100)));
			if (phase == 1) begin
				// The sender pauses until every report has come back.
				while (motion_q.size() != 0) @(negedge clk);
			end
			drain_results();
		end

		// Random part: mostly full gestures, the rest loose events.
		hold_rx = 1'b1;
		while (sent < N_RANDOM + 100) begin
			p = $urandom_range(0, 9);
			if (p < 7) begin
				if ($urandom_range(0, 3) != 0) send_event(make_ev(mse_pkg::MODE_START,
					$urandom, $urandom, $urandom));
				repeat ($urandom_range(0, 12)) begin
					send_event(rand_sample());
					idle_cycles(gap_len());
				end
				send_event(make_ev(mse_pkg::MODE_RELEASE, $urandom, $urandom, $urandom));
				repeat ($urandom_range(1, 10)) begin
					ev = make_ev(mse_pkg::MODE_TICK, $urandom, $urandom,
						($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 50));
					send_event(ev);
					idle_cycles(gap_len());
				end
			end else begin
				ev = make_ev(mse_pkg::mode_t'($urandom_range(0, 3)), $urandom, $urandom,
					$urandom);
				send_event(ev);
				idle_cycles(gap_len());
			end
			if ($urandom_range(0, 60) == 0) begin
				drain_results();
				write_coef(16'($urandom));
			end
		end

		drain_results();
		if (mismatches == 0 && motion_q.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end
endmodule
